// ----- rtl/core/plu_pkg.sv -----
// ----------------------------------------------------------------------------
// plu_pkg
// shared types and constants for the partition lexicographic unrank unit
// ----------------------------------------------------------------------------
package plu_pkg;

    localparam int TOTAL_W = 6;
    localparam int RANK_W  = 21;
    localparam int ADDR_W  = 2 * TOTAL_W;
    localparam int STAT_W  = 2;

    localparam logic [TOTAL_W-1:0] MAX_TOTAL = 6'd63;

    localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_BAD_SIZE = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_BAD_RANK = 2'd2;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [TOTAL_W-1:0] part_count;
        logic [RANK_W-1:0]  rank;
    } plu_in_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] part_value;
        logic [TOTAL_W-1:0] part_index;
        logic               last_part;
        logic [STAT_W-1:0]  status;
    } plu_out_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [TOTAL_W-1:0] part_count;
        logic [RANK_W-1:0]  rank;
        logic [STAT_W-1:0]  status;
    } plu_cmd_t;

endpackage

// ----- rtl/core/plu_table.sv -----
// ----------------------------------------------------------------------------
// plu_table
// table of partition counts P(i,j), filled by an init pass after reset,
// with two registered read ports
// ----------------------------------------------------------------------------
module plu_table
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [plu_pkg::ADDR_W-1:0]  rd_a_addr,
    input  logic [plu_pkg::ADDR_W-1:0]  rd_b_addr,
    output logic [plu_pkg::RANK_W-1:0]  rd_a_data,
    output logic [plu_pkg::RANK_W-1:0]  rd_b_data,
    output logic                        ready
);

    localparam logic [1:0] KIND_ZERO = 2'd0;
    localparam logic [1:0] KIND_ONE  = 2'd1;
    localparam logic [1:0] KIND_SUM  = 2'd2;
    localparam int DEPTH = 2 ** plu_pkg::ADDR_W;
    localparam logic [plu_pkg::ADDR_W-1:0] LAST_ADDR = '1;

    logic [plu_pkg::RANK_W-1:0] mem [DEPTH];

    logic                        init_run_reg, init_run_next;
    logic [plu_pkg::ADDR_W-1:0]  init_cnt_reg, init_cnt_next;
    logic                        wr_pend_reg, wr_pend_next;
    logic [plu_pkg::ADDR_W-1:0]  wr_addr_reg, wr_addr_next;
    logic [1:0]                  wr_kind_reg, wr_kind_next;
    logic                        ready_reg, ready_next;

    logic [plu_pkg::TOTAL_W-1:0] init_i, init_j;
    logic [plu_pkg::ADDR_W-1:0]  init_a_addr, init_b_addr;
    logic [plu_pkg::ADDR_W-1:0]  a_addr, b_addr;
    logic [1:0]                  init_kind;
    logic [plu_pkg::RANK_W:0]    sum;
    logic [plu_pkg::RANK_W-1:0]  wr_data;
    logic [plu_pkg::RANK_W-1:0]  rd_a_q, rd_b_q;

    assign init_i = init_cnt_reg[plu_pkg::ADDR_W-1:plu_pkg::TOTAL_W];
    assign init_j = init_cnt_reg[plu_pkg::TOTAL_W-1:0];

    always_comb
    begin
        priority if (init_i == '0 && init_j == '0)
        begin
            init_kind = KIND_ONE;
        end
        else if (init_j == '0 || init_j > init_i)
        begin
            init_kind = KIND_ZERO;
        end
        else
        begin
            init_kind = KIND_SUM;
        end
    end

    assign init_a_addr = {init_i - 1'b1, init_j - 1'b1};
    assign init_b_addr = {init_i - init_j, init_j};

    assign a_addr = init_run_reg ? init_a_addr : rd_a_addr;
    assign b_addr = init_run_reg ? init_b_addr : rd_b_addr;

    assign sum = {1'b0, rd_a_q} + {1'b0, rd_b_q};

    always_comb
    begin
        unique case (wr_kind_reg)
            KIND_ONE: wr_data = plu_pkg::RANK_W'(1);
            KIND_SUM: wr_data = sum[plu_pkg::RANK_W-1:0];
            default:  wr_data = '0;
        endcase
    end

    always_comb
    begin
        init_run_next = init_run_reg;
        init_cnt_next = init_cnt_reg;
        wr_pend_next  = init_run_reg;
        wr_addr_next  = init_cnt_reg;
        wr_kind_next  = init_kind;
        ready_next    = ready_reg;
        if (init_run_reg)
        begin
            init_cnt_next = init_cnt_reg + 1'b1;
            if (init_cnt_reg == LAST_ADDR)
            begin
                init_run_next = 1'b0;
            end
        end
        if (wr_pend_reg && wr_addr_reg == LAST_ADDR)
        begin
            ready_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_run_reg <= 1'b1;
            init_cnt_reg <= '0;
            wr_pend_reg  <= 1'b0;
            wr_addr_reg  <= '0;
            wr_kind_reg  <= KIND_ZERO;
            ready_reg    <= 1'b0;
        end
        else
        begin
            init_run_reg <= init_run_next;
            init_cnt_reg <= init_cnt_next;
            wr_pend_reg  <= wr_pend_next;
            wr_addr_reg  <= wr_addr_next;
            wr_kind_reg  <= wr_kind_next;
            ready_reg    <= ready_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_pend_reg)
        begin
            mem[wr_addr_reg] <= wr_data;
        end
        rd_a_q <= mem[a_addr];
        rd_b_q <= mem[b_addr];
    end

    assign rd_a_data = rd_a_q;
    assign rd_b_data = rd_b_q;
    assign ready     = ready_reg;

endmodule

// ----- rtl/core/plu_front.sv -----
// ----------------------------------------------------------------------------
// plu_front
// accepts requests, checks sizes and rank range, queues commands
// ----------------------------------------------------------------------------
module plu_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  plu_pkg::plu_in_t            request,
    output logic                        busy,
    input  logic                        table_ready,
    output logic [plu_pkg::ADDR_W-1:0]  rd_addr,
    input  logic [plu_pkg::RANK_W-1:0]  rd_data,
    output logic                        push,
    output plu_pkg::plu_cmd_t           push_cmd,
    input  logic                        full
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_LOOK = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]        state_reg, state_next;
    plu_pkg::plu_cmd_t cmd_reg, cmd_next;
    logic              accept, bad_size;

    assign busy    = !table_ready || state_reg != F_IDLE;
    assign accept  = start && !busy;
    assign rd_addr = {request.total, request.part_count};

    assign bad_size = request.part_count == '0
                   || request.part_count > request.total
                   || request.total > plu_pkg::MAX_TOTAL;

    assign push     = state_reg == F_PUSH && !full;
    assign push_cmd = cmd_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    cmd_next.total      = request.total;
                    cmd_next.part_count = request.part_count;
                    cmd_next.rank       = request.rank;
                    cmd_next.status     = plu_pkg::STATUS_BAD_SIZE;
                    state_next          = bad_size ? F_PUSH : F_LOOK;
                end
            end
            F_LOOK:
            begin
                cmd_next.status = (cmd_reg.rank >= rd_data) ? plu_pkg::STATUS_BAD_RANK
                                                            : plu_pkg::STATUS_OK;
                state_next      = F_PUSH;
            end
            F_PUSH:
            begin
                if (!full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

// ----- rtl/core/plu_queue.sv -----
// ----------------------------------------------------------------------------
// plu_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module plu_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  plu_pkg::plu_cmd_t push_cmd,
    output logic              full,
    input  logic              pop,
    output plu_pkg::plu_cmd_t pop_cmd,
    output logic              empty
);

    plu_pkg::plu_cmd_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full    = count_reg == 2'd2;
    assign empty   = count_reg == 2'd0;
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("pop from empty queue");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("queue count out of range");

endmodule

// ----- rtl/core/plu_back.sv -----
// ----------------------------------------------------------------------------
// plu_back
// walks the count table to build the partition and streams the parts, or one error result
// ----------------------------------------------------------------------------
module plu_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        empty,
    input  plu_pkg::plu_cmd_t           pop_cmd,
    output logic                        pop,
    output logic [plu_pkg::ADDR_W-1:0]  rd_addr,
    input  logic [plu_pkg::RANK_W-1:0]  rd_data,
    output logic                        result_strobe,
    output plu_pkg::plu_out_t           result
);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_STEP = 3'd1;
    localparam logic [2:0] B_CMP  = 3'd2;
    localparam logic [2:0] B_EMIT = 3'd3;
    localparam logic [2:0] B_ERR  = 3'd4;

    localparam int DEPTH = 2 ** plu_pkg::TOTAL_W;

    logic [plu_pkg::TOTAL_W-1:0] part_mem [DEPTH];

    logic [2:0]                  state_reg, state_next;
    logic [plu_pkg::TOTAL_W-1:0] m_reg, m_next;
    logic [plu_pkg::TOTAL_W-1:0] n_reg, n_next;
    logic [plu_pkg::RANK_W-1:0]  r_reg, r_next;
    logic [plu_pkg::TOTAL_W-1:0] base_reg, base_next;
    logic [plu_pkg::TOTAL_W-1:0] parts_reg, parts_next;
    logic [plu_pkg::TOTAL_W-1:0] k_reg, k_next;
    logic [plu_pkg::STAT_W-1:0]  err_reg, err_next;
    logic                        ev_reg, ev_next;
    logic [plu_pkg::TOTAL_W-1:0] idx_reg, idx_next;
    logic                        last_reg, last_next;
    logic [plu_pkg::STAT_W-1:0]  st_reg, st_next;
    logic [plu_pkg::TOTAL_W-1:0] buf_q;
    logic                        buf_we, emit_last;

    assign rd_addr   = {m_reg - 1'b1, n_reg - 1'b1};
    assign pop       = state_reg == B_IDLE && !empty;
    assign buf_we    = state_reg == B_CMP && r_reg < rd_data;
    assign emit_last = k_reg == parts_reg - 1'b1;

    always_comb
    begin
        state_next = state_reg;
        m_next     = m_reg;
        n_next     = n_reg;
        r_next     = r_reg;
        base_next  = base_reg;
        parts_next = parts_reg;
        k_next     = k_reg;
        err_next   = err_reg;
        ev_next    = 1'b0;
        idx_next   = idx_reg;
        last_next  = last_reg;
        st_next    = st_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    m_next     = pop_cmd.total;
                    n_next     = pop_cmd.part_count;
                    r_next     = pop_cmd.rank;
                    parts_next = pop_cmd.part_count;
                    base_next  = '0;
                    k_next     = '0;
                    err_next   = pop_cmd.status;
                    state_next = (pop_cmd.status == plu_pkg::STATUS_OK) ? B_STEP : B_ERR;
                end
            end
            B_STEP:
            begin
                state_next = B_CMP;
            end
            B_CMP:
            begin
                if (r_reg < rd_data)
                begin
                    m_next = m_reg - 1'b1;
                    n_next = n_reg - 1'b1;
                end
                else
                begin
                    base_next = base_reg + 1'b1;
                    r_next    = r_reg - rd_data;
                    m_next    = m_reg - n_reg;
                end
                state_next = (m_next == '0) ? B_EMIT : B_STEP;
            end
            B_EMIT:
            begin
                ev_next   = 1'b1;
                idx_next  = k_reg;
                last_next = emit_last;
                st_next   = plu_pkg::STATUS_OK;
                k_next    = k_reg + 1'b1;
                if (emit_last)
                begin
                    state_next = B_IDLE;
                end
            end
            B_ERR:
            begin
                ev_next    = 1'b1;
                idx_next   = '0;
                last_next  = 1'b1;
                st_next    = err_reg;
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            ev_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ev_reg    <= ev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg     <= m_next;
        n_reg     <= n_next;
        r_reg     <= r_next;
        base_reg  <= base_next;
        parts_reg <= parts_next;
        k_reg     <= k_next;
        err_reg   <= err_next;
        idx_reg   <= idx_next;
        last_reg  <= last_next;
        st_reg    <= st_next;
    end

    // a part closes with every group step taken so far plus its own step
    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            part_mem[n_reg - 1'b1] <= base_reg + 1'b1;
        end
        buf_q <= part_mem[k_reg];
    end

    assign result_strobe     = ev_reg;
    assign result.part_value = (st_reg == plu_pkg::STATUS_OK) ? buf_q : '0;
    assign result.part_index = idx_reg;
    assign result.last_part  = last_reg;
    assign result.status     = st_reg;

    a_walk_open: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_CMP |-> m_reg != '0 && n_reg != '0 && n_reg <= m_reg)
        else $error("walk step with no open part");
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result.status != plu_pkg::STATUS_OK |-> result.last_part)
        else $error("error result without last mark");
    a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_EMIT |-> k_reg < parts_reg)
        else $error("part index past part count");

endmodule

// ----- rtl/core/partition_lex_unrank_unit.sv -----
// ----------------------------------------------------------------------------
// partition_lex_unrank_unit
// unranks a partition of total into exactly part_count parts, lexicographic
// ----------------------------------------------------------------------------
// walk: at most total walk steps, each a step state and a compare state with
//   one table read; then one part per cycle, which cannot be stalled;
//   a bad size or bad rank request gives a single error result instead
// queueing: the front can accept a new request while the back still walks
//   earlier ones, until the two-entry queue is full
// reset: busy stays high while the init pass fills the table
// results are shown for one cycle each and cannot be stalled
// ----------------------------------------------------------------------------
module partition_lex_unrank_unit
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  plu_pkg::plu_in_t  request,
    output logic              busy,
    output logic              result_strobe,
    output plu_pkg::plu_out_t result
);

    logic [plu_pkg::ADDR_W-1:0] rd_a_addr, rd_b_addr;
    logic [plu_pkg::RANK_W-1:0] rd_a_data, rd_b_data;
    logic                       table_ready;
    logic                       push, pop, full, empty;
    plu_pkg::plu_cmd_t          push_cmd, pop_cmd;

    plu_table u_table
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data),
        .ready     (table_ready)
    );

    plu_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .request     (request),
        .busy        (busy),
        .table_ready (table_ready),
        .rd_addr     (rd_a_addr),
        .rd_data     (rd_a_data),
        .push        (push),
        .push_cmd    (push_cmd),
        .full        (full)
    );

    plu_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (empty)
    );

    plu_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .empty         (empty),
        .pop_cmd       (pop_cmd),
        .pop           (pop),
        .rd_addr       (rd_b_addr),
        .rd_data       (rd_b_data),
        .result_strobe (result_strobe),
        .result        (result)
    );

endmodule

// ----- test/tb_partition_lex_unrank_unit.sv -----
// ----------------------------------------------------------------------------
// tb_partition_lex_unrank_unit
// self-checking bench for the partition lexicographic unrank unit: an
// in-bench predictor of the count table and the unrank walk builds the
// expected parts of each accepted request, and every result beat is checked
// in order against them, under random sender gaps and directed corner cases
// ----------------------------------------------------------------------------
module tb_partition_lex_unrank_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIM          = 64;
    localparam int RANDOM_ITEMS = 446;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int TAIL_CYCLES  = 200;

    logic              clk;
    logic              rst_n;
    logic              start;
    plu_pkg::plu_in_t  request;
    logic              busy;
    logic              result_strobe;
    plu_pkg::plu_out_t result;

    logic [plu_pkg::RANK_W-1:0] partition_count [0:DIM-1][0:DIM-1];
    plu_pkg::plu_out_t          expected_parts[$];

    int  mismatch_count   = 0;
    int  parts_checked    = 0;
    int  unranked_count   = 0;
    int  bad_size_count   = 0;
    int  bad_rank_count   = 0;
    int  cycle_count      = 0;
    bit  idle_enable      = 1'b1;

    partition_lex_unrank_unit i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .request       (request),
        .busy          (busy),
        .result_strobe (result_strobe),
        .result        (result)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [plu_pkg::TOTAL_W-1:0] ix(input int unsigned v);
        return plu_pkg::TOTAL_W'(v);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic void predict_parts(input plu_pkg::plu_in_t req);
        logic [plu_pkg::TOTAL_W-1:0] acc [0:DIM-1];
        int unsigned                 remaining;
        int unsigned                 open_parts;
        int unsigned                 rank_left;
        int unsigned                 below;
        plu_pkg::plu_out_t           beat;
        beat = '0;
        beat.last_part = 1'b1;
        if (req.part_count == '0 || req.part_count > req.total
            || req.total > plu_pkg::MAX_TOTAL)
        begin
            beat.status = plu_pkg::STATUS_BAD_SIZE;
            expected_parts.push_back(beat);
            bad_size_count++;
            return;
        end
        if (req.rank >= partition_count[req.total][req.part_count])
        begin
            beat.status = plu_pkg::STATUS_BAD_RANK;
            expected_parts.push_back(beat);
            bad_rank_count++;
            return;
        end
        for (int i = 0; i < DIM; i++)
        begin
            acc[ix(i)] = '0;
        end
        remaining  = 32'(req.total);
        open_parts = 32'(req.part_count);
        rank_left  = 32'(req.rank);
        while (remaining > 0 && open_parts > 0 && open_parts <= remaining)
        begin
            below = 32'(partition_count[ix(remaining - 1)][ix(open_parts - 1)]);
            if (rank_left < below)
            begin
                acc[ix(open_parts - 1)] = acc[ix(open_parts - 1)] + 1'b1;
                remaining--;
                open_parts--;
            end
            else
            begin
                for (int unsigned i = 0; i < open_parts; i++)
                begin
                    acc[ix(i)] = acc[ix(i)] + 1'b1;
                end
                rank_left -= below;
                remaining -= open_parts;
            end
        end
        for (int k = 0; k < int'(req.part_count); k++)
        begin
            beat.part_value = acc[ix(k)];
            beat.part_index = ix(k);
            beat.last_part  = (k == int'(req.part_count) - 1);
            beat.status     = plu_pkg::STATUS_OK;
            expected_parts.push_back(beat);
        end
        unranked_count++;
    endfunction

    // request accepted at this edge, result beat shown in the cycle just ended
    always @(posedge clk)
    begin
        plu_pkg::plu_out_t want;
        if (rst_n && start && !busy)
        begin
            predict_parts(request);
        end
        if (rst_n && result_strobe)
        begin
            if (expected_parts.size() == 0)
            begin
                report_mismatch($sformatf("result beat with nothing expected: %p", result));
            end
            else
            begin
                want = expected_parts.pop_front();
                parts_checked++;
                if (result.part_value !== want.part_value)
                begin
                    report_mismatch($sformatf("part_value got %0d expected %0d",
                                              result.part_value, want.part_value));
                end
                if (result.part_index !== want.part_index)
                begin
                    report_mismatch($sformatf("part_index got %0d expected %0d",
                                              result.part_index, want.part_index));
                end
                if (result.last_part !== want.last_part)
                begin
                    report_mismatch($sformatf("last_part got %0d expected %0d",
                                              result.last_part, want.last_part));
                end
                if (result.status !== want.status)
                begin
                    report_mismatch($sformatf("status got %0d expected %0d",
                                              result.status, want.status));
                end
            end
        end
    end

    function automatic plu_pkg::plu_in_t make_request(input int unsigned total_v,
                                                      input int unsigned parts_v,
                                                      input int unsigned rank_v);
        plu_pkg::plu_in_t req;
        req.total      = plu_pkg::TOTAL_W'(total_v);
        req.part_count = plu_pkg::TOTAL_W'(parts_v);
        req.rank       = plu_pkg::RANK_W'(rank_v);
        return req;
    endfunction

    function automatic int unsigned count_of(input int unsigned total_v,
                                             input int unsigned parts_v);
        return 32'(partition_count[ix(total_v)][ix(parts_v)]);
    endfunction

    task automatic send_request(input plu_pkg::plu_in_t req);
        start   <= 1'b1;
        request <= req;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        if (idle_enable && $urandom_range(99) < 15)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
    endtask

    task automatic wait_for_drain();
        do
        begin
            @(posedge clk);
        end
        while (expected_parts.size() != 0);
    endtask

    task automatic test_size_limits();
        send_request(make_request(0, 0, 0));
        send_request(make_request(0, 1, 0));
        send_request(make_request(63, 0, 0));
        send_request(make_request(17, 18, 0));
        send_request(make_request(0, 63, 2097151));
        send_request(make_request(1, 1, 0));
        send_request(make_request(63, 1, 0));
        send_request(make_request(63, 63, 0));
        send_request(make_request(2, 2, 0));
        send_request(make_request(63, 2, count_of(63, 2) - 1));
    endtask

    task automatic test_rank_limits();
        send_request(make_request(5, 2, count_of(5, 2)));
        send_request(make_request(63, 63, 1));
        send_request(make_request(1, 1, 1));
        send_request(make_request(40, 10, 2097151));
        send_request(make_request(63, 20, 0));
        send_request(make_request(63, 20, count_of(63, 20) - 1));
        send_request(make_request(63, 10, count_of(63, 10) / 2));
        send_request(make_request(63, 32, count_of(63, 32) - 1));
        send_request(make_request(63, 12, count_of(63, 12)));
        send_request(make_request(30, 7, count_of(30, 7) - 1));
        send_request(make_request(12, 4, 5));
    endtask

    task automatic test_drain_pause();
        send_request(make_request(48, 6, count_of(48, 6) - 1));
        send_request(make_request(20, 5, 3));
        start <= 1'b0;
        wait_for_drain();
        send_request(make_request(63, 31, 0));
    endtask

    task automatic test_random_mix();
        plu_pkg::plu_in_t req;
        int unsigned      total_v;
        int unsigned      parts_v;
        int unsigned      limit_v;
        int unsigned      pick;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            idle_enable = !(n >= 200 && n < 320);
            pick    = $urandom_range(99);
            total_v = $urandom_range(1, 63);
            parts_v = $urandom_range(1, total_v);
            limit_v = count_of(total_v, parts_v);
            if (pick < 70)
            begin
                req = make_request(total_v, parts_v, $urandom_range(0, limit_v - 1));
            end
            else if (pick < 78)
            begin
                req = make_request(total_v, parts_v, limit_v - 1);
            end
            else if (pick < 88)
            begin
                req = make_request(total_v, parts_v, $urandom_range(limit_v, 2097151));
            end
            else
            begin
                req.total      = plu_pkg::TOTAL_W'($urandom);
                req.part_count = plu_pkg::TOTAL_W'($urandom);
                req.rank       = plu_pkg::RANK_W'($urandom);
            end
            send_request(req);
            if (n == 350)
            begin
                start <= 1'b0;
                wait_for_drain();
            end
        end
        start <= 1'b0;
    endtask

    initial
    begin
        for (int i = 0; i < DIM; i++)
        begin
            for (int j = 0; j < DIM; j++)
            begin
                partition_count[ix(i)][ix(j)] = '0;
            end
        end
        partition_count[ix(0)][ix(0)] = plu_pkg::RANK_W'(1);
        for (int i = 1; i < DIM; i++)
        begin
            for (int j = 1; j <= i; j++)
            begin
                partition_count[ix(i)][ix(j)] = partition_count[ix(i - 1)][ix(j - 1)]
                                              + partition_count[ix(i - j)][ix(j)];
            end
        end

        rst_n   <= 1'b0;
        start   <= 1'b0;
        request <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_size_limits();
        test_rank_limits();
        test_drain_pause();
        test_random_mix();

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("requests: %0d unranked, %0d bad size, %0d rank too large",
                 unranked_count, bad_size_count, bad_rank_count);
        $display("result beats checked: %0d in %0d cycles", parts_checked, cycle_count);
        if (mismatch_count == 0 && expected_parts.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
